/* rtl/ffbp_pkg.sv */
package ffbp_pkg;

    // default number of bins
    localparam int DEF_MAX_BINS = 64;

    // field widths
    localparam int SIZE_W   = 48;
    localparam int FILES_W  = 32;
    localparam int TOTAL_W  = 64;
    localparam int INDEX_W  = 6;
    localparam int INUSE_W  = 7;

    // stream widths, data padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 112;
    localparam int M_USER_W = 2;

    // configuration port
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FILES = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SIZE  = 8'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

endpackage

/* rtl/first_fit_bin_packing_top.sv */
// the scan loop reads one bin per cycle and tests the previously read one in the add and
// compare unit; an oversized item goes straight to the overflow bin
// one request at a time: a new request is taken only after the result is loaded for output
// reset: synchronous active low, clears limits, open bin count and handshake state;
// the bin memory is not swept, stale entries are masked by the open bin count
module first_fit_bin_packing_top #(
    parameter int MAX_BINS = ffbp_pkg::DEF_MAX_BINS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ffbp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ffbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [ffbp_pkg::S_DATA_W-1:0]   i_s_axis_tdata,  // item_size[47:0]
    input  logic [ffbp_pkg::S_USER_W-1:0]   i_s_axis_tuser,  // first_of_job[0]
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // bin_index[5:0], bin_files_after[37:6], bin_size_after[101:38],
    // bins_in_use[108:102], zero[111:109]
    output logic [ffbp_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    // to_overflow[0], no_room[1]
    output logic [ffbp_pkg::M_USER_W-1:0]   o_m_axis_tuser
);
    import ffbp_pkg::*;

    localparam int IW = $clog2(MAX_BINS);
    localparam int OW = $clog2(MAX_BINS + 1);

    // state and registers
    t_state                 r_state, n_state;
    logic [FILES_W-1:0]     r_max_files;
    logic [SIZE_W-1:0]      r_max_size;
    logic [OW-1:0]          r_open, n_open;
    logic [OW-1:0]          r_vlim, n_vlim;
    logic                   r_bin0_ok, n_bin0_ok;
    logic                   r_bin1_ok, n_bin1_ok;
    logic [SIZE_W-1:0]      r_size, n_size;
    logic                   r_over, n_over;
    logic [OW-1:0]          r_k, n_k;
    logic                   r_chk_v, n_chk_v;
    logic [IW-1:0]          r_chk_k, n_chk_k;
    logic [IW-1:0]          r_chosen, n_chosen;
    logic [TOTAL_W-1:0]     r_cur_total, n_cur_total;
    logic [FILES_W-1:0]     r_cur_items, n_cur_items;
    logic                   r_nr, n_nr;
    logic [TOTAL_W-1:0]     r_rd_total;
    logic [FILES_W-1:0]     r_rd_items;
    logic                   r_out_valid;
    logic [M_DATA_W-1:0]    r_out_data;
    logic [M_USER_W-1:0]    r_out_user;

    // bin memory
    logic [TOTAL_W-1:0]     mem_total [MAX_BINS];
    logic [FILES_W-1:0]     mem_items [MAX_BINS];

    // datapath
    logic                   s_acc, cfg_acc, out_free, load_out;
    logic                   chk_valid, fit, take, more, base;
    logic [TOTAL_W-1:0]     chk_total, sat_total, upd_total;
    logic [FILES_W-1:0]     chk_items, upd_items;
    logic [TOTAL_W:0]       chk_sum, upd_sum;
    logic [OW-1:0]          open_c;
    logic [OW+INUSE_W-1:0]  inuse_ext;
    logic [IW+INDEX_W-1:0]  index_ext;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign load_out = (r_state == ST_UPD) && out_free;
    assign base     = (r_max_size != '0);
    assign more     = (r_k < r_open);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // fit test on the bin read last cycle, stale entries read as empty
    // bins 0 and 1 may be opened at job start without a write, so each has its own flag
    always_comb begin
        if (r_chk_k == '0) begin
            chk_valid = r_bin0_ok;
        end else if (r_chk_k == IW'(1)) begin
            chk_valid = r_bin1_ok;
        end else begin
            chk_valid = (OW'(r_chk_k) < r_vlim);
        end
        chk_total = chk_valid ? r_rd_total : '0;
        chk_items = chk_valid ? r_rd_items : '0;
        chk_sum   = {1'b0, chk_total} + (TOTAL_W + 1)'(r_size);
        sat_total = chk_sum[TOTAL_W] ? '1 : chk_sum[TOTAL_W-1:0];
        fit = ((r_max_files == '0) || (chk_items < r_max_files)) &&
              ((r_max_size == '0) || (sat_total <= TOTAL_W'(r_max_size)));
        take = r_chk_v && (r_over || fit);
    end

    // saturating update of the chosen bin
    always_comb begin
        upd_sum   = {1'b0, r_cur_total} + (TOTAL_W + 1)'(r_size);
        upd_total = upd_sum[TOTAL_W] ? '1 : upd_sum[TOTAL_W-1:0];
        upd_items = (r_cur_items == '1) ? r_cur_items : r_cur_items + 1'b1;
        inuse_ext = (OW + INUSE_W)'(r_open);
        index_ext = (IW + INDEX_W)'(r_chosen);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (take || !more) n_state = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        n_open      = r_open;
        n_vlim      = r_vlim;
        n_bin0_ok   = r_bin0_ok;
        n_bin1_ok   = r_bin1_ok;
        n_size      = r_size;
        n_over      = r_over;
        n_k         = r_k;
        n_chk_v     = r_chk_v;
        n_chk_k     = r_chk_k;
        n_chosen    = r_chosen;
        n_cur_total = r_cur_total;
        n_cur_items = r_cur_items;
        n_nr        = r_nr;
        open_c      = i_s_axis_tuser[0] ? '0 : r_open;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    // job start clears bins and opens the first ones
                    n_size    = i_s_axis_tdata[SIZE_W-1:0];
                    n_vlim    = open_c;
                    n_open    = (open_c == '0) ? OW'(base) + 1'b1 : open_c;
                    n_bin0_ok = i_s_axis_tuser[0] ? 1'b0 : r_bin0_ok;
                    n_bin1_ok = i_s_axis_tuser[0] ? 1'b0 : r_bin1_ok;
                    n_over    = base && (i_s_axis_tdata[SIZE_W-1:0] > r_max_size);
                    n_k       = (base && (i_s_axis_tdata[SIZE_W-1:0] > r_max_size))
                                ? '0 : OW'(base);
                    n_chk_v   = 1'b0;
                end
            end
            ST_SCAN: begin
                // read one bin per cycle, test the previous one
                n_chk_v = more;
                n_chk_k = r_k[IW-1:0];
                if (more) n_k = r_k + 1'b1;
                if (take) begin
                    n_chosen    = r_chk_k;
                    n_cur_total = chk_total;
                    n_cur_items = chk_items;
                    n_nr        = 1'b0;
                end else if (!more) begin
                    if (r_open < OW'(MAX_BINS)) begin
                        n_chosen    = r_open[IW-1:0];
                        n_cur_total = '0;
                        n_cur_items = '0;
                        n_open      = r_open + 1'b1;
                        n_nr        = 1'b0;
                    end else begin
                        n_nr = 1'b1;
                    end
                end
            end
            ST_UPD: begin
                if (out_free && !r_nr && (r_chosen == '0)) n_bin0_ok = 1'b1;
                if (out_free && !r_nr && (r_chosen == IW'(1))) n_bin1_ok = 1'b1;
            end
            default: begin
                n_nr = r_nr;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_files <= '0;
            r_max_size  <= '0;
            r_open      <= '0;
            r_bin0_ok   <= 1'b0;
            r_bin1_ok   <= 1'b0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_open    <= n_open;
            r_bin0_ok <= n_bin0_ok;
            r_bin1_ok <= n_bin1_ok;
            r_chk_v   <= n_chk_v;
            if (cfg_acc) begin
                case (i_cfg_addr)
                    CFG_MAX_FILES: r_max_files <= i_cfg_data[FILES_W-1:0];
                    CFG_MAX_SIZE:  r_max_size  <= i_cfg_data[SIZE_W-1:0];
                    default:       r_max_size  <= r_max_size;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_vlim      <= n_vlim;
        r_size      <= n_size;
        r_over      <= n_over;
        r_k         <= n_k;
        r_chk_k     <= n_chk_k;
        r_chosen    <= n_chosen;
        r_cur_total <= n_cur_total;
        r_cur_items <= n_cur_items;
        r_nr        <= n_nr;
        if (load_out) begin
            if (r_nr) begin
                r_out_data <= {3'b000, inuse_ext[INUSE_W-1:0], {TOTAL_W{1'b0}},
                               {FILES_W{1'b0}}, {INDEX_W{1'b0}}};
                r_out_user <= 2'b10;
            end else begin
                r_out_data <= {3'b000, inuse_ext[INUSE_W-1:0], upd_total,
                               upd_items, index_ext[INDEX_W-1:0]};
                r_out_user <= {1'b0, r_over};
            end
        end
    end

    // bin memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (load_out && !r_nr) begin
            mem_total[r_chosen] <= upd_total;
            mem_items[r_chosen] <= upd_items;
        end
        r_rd_total <= mem_total[r_k[IW-1:0]];
        r_rd_items <= mem_items[r_k[IW-1:0]];
    end

    // checks
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OW'(MAX_BINS))
        else $error("open bin count beyond bin capacity");

    a_acc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_SCAN) && (r_open != '0))
        else $error("request not followed by a scan with open bins");

    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ST_UPD))
        else $error("result raised outside the update step");

    a_over_bin0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && take && r_over |-> (r_chk_k == '0))
        else $error("oversized item not placed in the overflow bin");

    a_noroom_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> !o_m_axis_tuser[0])
        else $error("no room flagged together with overflow");

endmodule

/* tb/ffbp_placement_checker.sv */
module ffbp_placement_checker #(
    parameter int MAX_BINS = ffbp_pkg::DEF_MAX_BINS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ffbp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ffbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [ffbp_pkg::S_DATA_W-1:0]   i_s_axis_tdata,  // item_size[47:0]
    input  logic [ffbp_pkg::S_USER_W-1:0]   i_s_axis_tuser,  // first_of_job[0]
    // output stream
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // bin_index[5:0], bin_files_after[37:6], bin_size_after[101:38],
    // bins_in_use[108:102], zero[111:109]
    input  logic [ffbp_pkg::M_DATA_W-1:0]   i_m_axis_tdata,
    // to_overflow[0], no_room[1]
    input  logic [ffbp_pkg::M_USER_W-1:0]   i_m_axis_tuser,
    output int                              o_mismatches,
    output int                              o_pending
);

    import ffbp_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0] bin;
        logic [FILES_W-1:0] files;
        logic [TOTAL_W-1:0] total;
        logic [INUSE_W-1:0] in_use;
        logic               overflow;
        logic               no_room;
    } placement_t;

    // own copy of the bin contents and the limits
    logic [TOTAL_W-1:0] fill_total [MAX_BINS];
    logic [FILES_W-1:0] fill_count [MAX_BINS];
    int unsigned        bins_open;
    logic [FILES_W-1:0] lim_files;
    logic [SIZE_W-1:0]  lim_size;

    // placements still to be seen on the output stream, oldest first
    placement_t placements_due [$];

    function automatic logic [TOTAL_W-1:0] sat_sum(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] widen(input logic [SIZE_W-1:0] v);
        return {{(TOTAL_W-SIZE_W){1'b0}}, v};
    endfunction

    function automatic bit bin_takes(input int k, input logic [SIZE_W-1:0] size);
        if (lim_files != '0 && fill_count[k] >= lim_files)
            return 1'b0;
        if (lim_size != '0 && sat_sum(fill_total[k], widen(size)) > widen(lim_size))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void empty_bins();
        for (int k = 0; k < MAX_BINS; k++) begin
            fill_total[k] = '0;
            fill_count[k] = '0;
        end
        bins_open = 0;
    endfunction

    // first-fit placement of one item, updating the bin contents
    function automatic placement_t place_item(input logic [SIZE_W-1:0] size,
                                              input logic new_job);
        placement_t  r;
        int unsigned base;
        int          chosen;
        bit          found;
        bit          over;
        base   = (lim_size != '0) ? 1 : 0;
        chosen = 0;
        found  = 1'b0;
        over   = 1'b0;
        if (new_job)
            empty_bins();
        if (bins_open == 0)
            bins_open = base + 1;
        if (lim_size != '0 && size > lim_size) begin
            found = 1'b1;
            over  = 1'b1;
        end else begin
            for (int k = base; k < bins_open && k < MAX_BINS; k++) begin
                if (!found && bin_takes(k, size)) begin
                    chosen = k;
                    found  = 1'b1;
                end
            end
            if (!found && bins_open < MAX_BINS) begin
                chosen    = bins_open;
                bins_open = bins_open + 1;
                found     = 1'b1;
            end
        end
        r.in_use = bins_open[INUSE_W-1:0];
        if (!found) begin
            r.bin      = '0;
            r.files    = '0;
            r.total    = '0;
            r.overflow = 1'b0;
            r.no_room  = 1'b1;
            return r;
        end
        fill_total[chosen] = sat_sum(fill_total[chosen], widen(size));
        if (fill_count[chosen] != {FILES_W{1'b1}})
            fill_count[chosen] = fill_count[chosen] + 1'b1;
        r.bin      = chosen[INDEX_W-1:0];
        r.files    = fill_count[chosen];
        r.total    = fill_total[chosen];
        r.overflow = over;
        r.no_room  = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    // follow the channels, predict on each request, compare on each result
    always @(posedge i_clk) begin : monitor
        placement_t want;
        if (!i_rst_n) begin
            empty_bins();
            lim_files = '0;
            lim_size  = '0;
            placements_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr == CFG_MAX_FILES)
                    lim_files = i_cfg_data[FILES_W-1:0];
                else if (i_cfg_addr == CFG_MAX_SIZE)
                    lim_size = i_cfg_data[SIZE_W-1:0];
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                placements_due.push_back(place_item(i_s_axis_tdata[SIZE_W-1:0],
                                                    i_s_axis_tuser[0]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (placements_due.size() == 0) begin
                    $error("result with no request outstanding: bin_index %0d",
                           i_m_axis_tdata[5:0]);
                    o_mismatches++;
                end else begin
                    want = placements_due.pop_front();
                    check_field("bin_index", want.bin, i_m_axis_tdata[5:0]);
                    check_field("bin_files_after", want.files, i_m_axis_tdata[37:6]);
                    check_field("bin_size_after", want.total, i_m_axis_tdata[101:38]);
                    check_field("bins_in_use", want.in_use, i_m_axis_tdata[108:102]);
                    check_field("padding", '0, i_m_axis_tdata[111:109]);
                    check_field("to_overflow", want.overflow, i_m_axis_tuser[0]);
                    check_field("no_room", want.no_room, i_m_axis_tuser[1]);
                end
            end
        end
        o_pending = placements_due.size();
    end

endmodule

/* tb/first_fit_bin_packing_top_test.sv */
module first_fit_bin_packing_top_test;

    import ffbp_pkg::*;

    localparam int N_PHASES     = 14;
    localparam int PHASE_ITEMS  = 66;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;

    int mismatches;
    int pending;
    int quiet = 0;
    int gap_pct;
    int stall_pct;
    bit calm;
    bit hold_req;

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    first_fit_bin_packing_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    ffbp_placement_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random ready bursts, one long hold-off on request
    initial begin : result_sink
        int n;
        bit held;
        m_tready = 1'b0;
        held     = 1'b0;
        forever begin
            if (hold_req && !held) begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (calm || $urandom_range(0, 99) >= stall_pct) begin
                m_tready = 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end else begin
                m_tready = 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end
        end
    end

    // register write, entered just after a falling edge
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_addr  = addr;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input logic [FILES_W-1:0] files, input logic [SIZE_W-1:0] size);
        logic [15:0] junk;
        junk = 16'($urandom);
        // upper bits of the count write carry noise, they must be dropped
        write_reg(CFG_MAX_FILES, {junk, files});
        write_reg(CFG_MAX_SIZE, size);
    endtask

    // one placement request, with an optional gap afterwards
    task automatic send_item(input logic [SIZE_W-1:0] size, input logic new_job);
        int n;
        s_tvalid = 1'b1;
        s_tdata  = size;
        s_tuser  = new_job;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clk);
        end
    endtask

    // stop offering and wait for every result to come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // item sizes mostly within the current size limit
    function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] lim);
        logic [63:0] r;
        logic [63:0] v;
        int          sel;
        r   = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (sel < 5)
            v = '0;
        else if (sel < 15)
            v = r;
        else if (sel < 20)
            v = '1;
        else if (lim == '0)
            v = r % 5001;
        else if (sel < 60)
            v = r % ({16'b0, lim} / 4 + 1);
        else if (sel < 85)
            v = r % ({16'b0, lim} + 1);
        else if (sel < 90)
            v = {16'b0, lim};
        else
            v = {16'b0, lim} + 1 + r % 1000;
        return v[SIZE_W-1:0];
    endfunction

    function automatic logic [FILES_W-1:0] pick_files();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 1;
            2: return $urandom_range(2, 8);
            3: return $urandom;
            default: return '1;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_limit();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 1;
            2: return SIZE_W'($urandom_range(2, 5000));
            3: return r[SIZE_W-1:0];
            default: return '1;
        endcase
    endfunction

    initial begin : stimulus
        logic [FILES_W-1:0] files_cfg;
        logic [SIZE_W-1:0]  size_cfg;
        logic               job_start;
        int                 job_pct;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        rst_n     = 1'b0;
        gap_pct   = 25;
        stall_pct = 25;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // limits at reset: everything lands in bin 0
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item('1, 1'b0);
        send_item(1, 1'b1);
        drain();

        // size limit 100 and two files: overflow bin, exact fit, full count
        set_limits(2, 100);
        send_item(100, 1'b1);
        send_item(101, 1'b0);
        send_item(0, 1'b0);
        send_item(0, 1'b0);
        send_item(60, 1'b0);
        send_item(41, 1'b0);
        send_item('1, 1'b0);
        send_item(59, 1'b0);
        drain();

        // limits changed in the middle of a job
        set_limits(1, 0);
        send_item(5, 1'b0);
        send_item(0, 1'b0);
        drain();

        // random phases over a range of limit settings
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin files_cfg = 1;  size_cfg = '0;  end
                1: begin files_cfg = 1;  size_cfg = '1;  end
                2: begin files_cfg = '0; size_cfg = '1;  end
                3: begin files_cfg = '1; size_cfg = '0;  end
                4: begin files_cfg = '0; size_cfg = 1;   end
                5: begin files_cfg = 3;  size_cfg = 1000; end
                default: begin
                    files_cfg = pick_files();
                    size_cfg  = pick_limit();
                end
            endcase
            set_limits(files_cfg, size_cfg);
            job_pct   = (p < 2) ? 0 : 3;
            job_start = (p < 6) ? 1'b1 : logic'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 60;
            endcase
            if (p == N_PHASES - 1)
                calm = 1'b1;
            // output held off long enough for the input to back up
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 0)
                    send_item(pick_size(size_cfg), job_start);
                else
                    send_item(pick_size(size_cfg), $urandom_range(0, 99) < job_pct);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
